>>> rtl/core/lei_pkg.sv
package lei_pkg;

  localparam int Q_W     = 32;  // Q8.24 coordinate width
  localparam int FRAC_W  = 24;
  localparam int SIGMA_W = 29;
  localparam int RHO_W   = 30;
  localparam int BETA_W  = 27;
  localparam int DT_W    = 25;
  localparam int CNT_W   = 17;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int OP_W    = Q_W + 1;             // multiplier operand width
  localparam int PROD_W  = 2 * OP_W;            // full product width
  localparam int SHP_W   = PROD_W - FRAC_W;     // product after the 24-bit shift
  localparam int ACC_W   = SHP_W + 1;           // adder width
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SIGMA  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RHO    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BETA   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DT     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RUNLEN = 3'd4;

  localparam logic [SIGMA_W-1:0] SIGMA_RST  = 29'd167772160;
  localparam logic [RHO_W-1:0]   RHO_RST    = 30'd469762048;
  localparam logic [BETA_W-1:0]  BETA_RST   = 27'd44739243;
  localparam logic [DT_W-1:0]    DT_RST     = 25'd83886;
  localparam logic [CNT_W-1:0]   RUNLEN_RST = 17'd10000;

  localparam logic signed [Q_W-1:0] START_X = 32'sd1677722;  // 0.1 in Q8.24

  localparam logic signed [ACC_W-1:0] ACC_MAX = 43'sd2147483647;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -43'sd2147483648;
  localparam logic signed [Q_W-1:0]   Q_MAX   = 32'sh7fffffff;
  localparam logic signed [Q_W-1:0]   Q_MIN   = 32'sh80000000;

  typedef struct packed {
    logic [SIGMA_W-1:0] sigma;
    logic [RHO_W-1:0]   rho;
    logic [BETA_W-1:0]  beta;
    logic [DT_W-1:0]    time_step;
    logic [CNT_W-1:0]   run_length;
  } cfg_t;

  // Clamp a wide signed value to the Q8.24 range.
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_MAX) begin
      return Q_MAX;
    end else if (v < ACC_MIN) begin
      return Q_MIN;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

endpackage

>>> rtl/core/lei_in_if.sv
interface lei_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

>>> rtl/core/lei_out_if.sv
interface lei_out_if import lei_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [Q_W-1:0]   x_out;
  logic signed [Q_W-1:0]   y_out;
  logic signed [Q_W-1:0]   z_out;
  logic [CNT_W-1:0]        step_index;
  logic                    run_last;

  modport source (output valid, output x_out, output y_out, output z_out,
                  output step_index, output run_last, input ready);
  modport sink (input valid, input x_out, input y_out, input z_out,
                input step_index, input run_last, output ready);
endinterface

>>> rtl/core/lei_regs.sv
module lei_regs import lei_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma      <= SIGMA_RST;
      cfg.rho        <= RHO_RST;
      cfg.beta       <= BETA_RST;
      cfg.time_step  <= DT_RST;
      cfg.run_length <= RUNLEN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SIGMA:  cfg.sigma      <= pwdata[SIGMA_W-1:0];
        REG_RHO:    cfg.rho        <= pwdata[RHO_W-1:0];
        REG_BETA:   cfg.beta       <= pwdata[BETA_W-1:0];
        REG_DT:     cfg.time_step  <= pwdata[DT_W-1:0];
        REG_RUNLEN: cfg.run_length <= pwdata[CNT_W-1:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIGMA:  prdata = DATA_W'(cfg.sigma);
      REG_RHO:    prdata = DATA_W'(cfg.rho);
      REG_BETA:   prdata = DATA_W'(cfg.beta);
      REG_DT:     prdata = DATA_W'(cfg.time_step);
      REG_RUNLEN: prdata = DATA_W'(cfg.run_length);
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/lei_mul.sv
module lei_mul import lei_pkg::*; (
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output logic signed [PROD_W-1:0] prod
);

  // Full signed product, registered; a new pair may enter every cycle.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> rtl/core/lorenz_euler_integrator_top.sv
// Lorenz integrator, one forward Euler step per tick transaction, signed Q8.24.
// The point is registered into the output register from FIN, or from OUT while
//   that register is still full; a new tick is taken only in IDLE. The single shared
//   33x33 multiplier does seven dependent products per step, one per cycle.
// Reset (rst, synchronous): coefficients to defaults, point to (0.1, 0, 0),
//   index 0 and the run marked finished, so the first tick reloads the start.
module lorenz_euler_integrator_top import lei_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  lei_in_if.sink            tick,
  lei_out_if.source         point
);

  // Sequencer states. M1..M7 each issue one product; FIN adds the last one.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_M4   = 4'd4;
  localparam logic [3:0] S_M5   = 4'd5;
  localparam logic [3:0] S_M6   = 4'd6;
  localparam logic [3:0] S_M7   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  cfg_t cfg;

  lei_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [3:0] state;

  // Integrator state
  logic signed [Q_W-1:0] pos_x, pos_y, pos_z;
  logic [CNT_W-1:0]      point_count;
  logic                  run_done;

  // Step scratch registers
  logic signed [OP_W-1:0]  diff;   // y - x, then rho - z
  logic signed [SHP_W-1:0] xy_q;   // x*y after the shift
  logic signed [Q_W-1:0]   dx, dy, dz;

  // Output register
  logic                  out_valid;
  logic signed [Q_W-1:0] out_x, out_y, out_z;
  logic [CNT_W-1:0]      out_idx;
  logic                  out_last;

  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_q;     // product >>> 24, sign extended
  logic signed [ACC_W-1:0]  add_a, add_b, add_sum;
  logic                     add_sub;
  logic signed [Q_W-1:0]    add_sat;
  logic                     accept, out_free, out_load, last;

  lei_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign accept   = tick.valid && tick.ready;
  assign out_free = !out_valid || point.ready;
  // A finished point moves into the output register this cycle.
  assign out_load = out_free && ((state == S_FIN) || (state == S_OUT));
  assign prod_q   = {prod[PROD_W-1], prod[PROD_W-1:FRAC_W]};
  assign last     = ({1'b0, point_count} + 1'b1) >= {1'b0, cfg.run_length};

  assign tick.ready       = (state == S_IDLE);
  assign point.valid      = out_valid;
  assign point.x_out      = out_x;
  assign point.y_out      = out_y;
  assign point.z_out      = out_z;
  assign point.step_index = out_idx;
  assign point.run_last   = out_last;

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M1: begin mul_a = {pos_x[Q_W-1], pos_x};     mul_b = {pos_y[Q_W-1], pos_y}; end
      S_M2: begin mul_a = OP_W'(cfg.sigma);          mul_b = diff;                  end
      S_M3: begin mul_a = {pos_x[Q_W-1], pos_x};     mul_b = diff;                  end
      S_M4: begin mul_a = OP_W'(cfg.beta);           mul_b = {pos_z[Q_W-1], pos_z}; end
      S_M5: begin mul_a = {dx[Q_W-1], dx};           mul_b = OP_W'(cfg.time_step);  end
      S_M6: begin mul_a = {dy[Q_W-1], dy};           mul_b = OP_W'(cfg.time_step);  end
      S_M7: begin mul_a = {dz[Q_W-1], dz};           mul_b = OP_W'(cfg.time_step);  end
      default: ;
    endcase
  end

  // Shared adder operand selection
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    unique case (state)
      S_M1: begin add_a = ACC_W'(pos_y);      add_b = ACC_W'(pos_x); end
      S_M2: begin add_a = ACC_W'(cfg.rho);    add_b = ACC_W'(pos_z); end
      S_M4: begin add_a = prod_q;             add_b = ACC_W'(pos_y); end
      S_M5: begin add_a = ACC_W'(xy_q);       add_b = prod_q;        end
      S_M6: begin add_a = ACC_W'(pos_x);      add_b = prod_q; add_sub = 1'b0; end
      S_M7: begin add_a = ACC_W'(pos_y);      add_b = prod_q; add_sub = 1'b0; end
      S_FIN: begin add_a = ACC_W'(pos_z);     add_b = prod_q; add_sub = 1'b0; end
      default: ;
    endcase
  end

  assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign add_sat = sat32(add_sum);

  // Load a finished point; otherwise drop the point once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (point.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos_x       <= START_X;
      pos_y       <= '0;
      pos_z       <= '0;
      point_count <= '0;
      run_done    <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (tick.restart || run_done) begin
              pos_x       <= START_X;
              pos_y       <= '0;
              pos_z       <= '0;
              point_count <= '0;
              run_done    <= 1'b0;
            end
            state <= S_M1;
          end
        end
        S_M1: begin
          diff  <= add_sum[OP_W-1:0];          // y - x
          state <= S_M2;
        end
        S_M2: begin
          xy_q  <= prod_q[SHP_W-1:0];          // x*y
          diff  <= add_sum[OP_W-1:0];          // rho - z
          state <= S_M3;
        end
        S_M3: begin
          dx    <= sat32(prod_q);              // sigma*(y - x)
          state <= S_M4;
        end
        S_M4: begin
          dy    <= add_sat;                    // x*(rho - z) - y
          state <= S_M5;
        end
        S_M5: begin
          dz    <= add_sat;                    // x*y - beta*z
          state <= S_M6;
        end
        S_M6: begin
          pos_x <= add_sat;
          state <= S_M7;
        end
        S_M7: begin
          pos_y <= add_sat;
          state <= S_FIN;
        end
        S_FIN: begin
          pos_z <= add_sat;
          if (out_free) begin
            out_x     <= pos_x;
            out_y     <= pos_y;
            out_z     <= add_sat;
            out_idx   <= point_count;
            out_last  <= last;
            if (last) begin
              run_done <= 1'b1;
            end else begin
              point_count <= point_count + 1'b1;
            end
            state <= S_IDLE;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold the finished point until the output register frees up.
          if (out_free) begin
            out_x     <= pos_x;
            out_y     <= pos_y;
            out_z     <= pos_z;
            out_idx   <= point_count;
            out_last  <= last;
            if (last) begin
              run_done <= 1'b1;
            end else begin
              point_count <= point_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
